### hdl/spmix_pkg.sv
// Shared types, sizes and helpers for the sample playback mixer.
`timescale 1ns / 1ps
`default_nettype none

package spmix_pkg;

    // Sizes
    localparam int CHANNELS     = 2;
    localparam int STORE_DEPTH  = 16384;           // power of two, wraps by mask
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int SUM_W        = (ADDR_W > 16) ? ADDR_W : 16;
    localparam int WADDR_W      = (ADDR_W > 14) ? ADDR_W : 14;
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH    = 4;
    localparam int OPTR_W       = $clog2(OUT_DEPTH);
    localparam int OCNT_W       = $clog2(OUT_DEPTH + 1);
    localparam int ACC_W        = 10 + $clog2(CHANNELS);
    localparam int NUM_VOL_REGS = 2;

    localparam logic [14:0] LENGTH_CAP = 15'd16384;
    localparam logic [7:0]  VOL_RESET  = 8'd255;
    localparam logic signed [ACC_W:0] DAC_OFFSET = (ACC_W + 1)'(128);
    localparam logic signed [ACC_W:0] DAC_MAX    = (ACC_W + 1)'(255);

    // Cursor increments, 8 fraction bits
    localparam logic [10:0] STEP_1K  = 11'(255 / 8);
    localparam logic [10:0] STEP_2K  = 11'(255 / 4);
    localparam logic [10:0] STEP_4K  = 11'(255 / 2);
    localparam logic [10:0] STEP_8K  = 11'(255);
    localparam logic [10:0] STEP_16K = 11'(255 * 2);
    localparam logic [10:0] STEP_32K = 11'(255 * 4);

    // Input action codes
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_PLAY  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Rate codes
    typedef enum logic [2:0] {
        RATE_1K  = 3'd0,
        RATE_2K  = 3'd1,
        RATE_4K  = 3'd2,
        RATE_8K  = 3'd3,
        RATE_16K = 3'd4,
        RATE_32K = 3'd5
    } rate_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_VOLUME_CH0 = 1'b0,
        CFG_VOLUME_CH1 = 1'b1
    } cfg_reg_t;

    // Queued operation kinds
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PLAY  = 2'd1,
        OP_WRITE = 2'd2
    } op_kind_t;

    // One classified operation between front and back
    typedef struct packed {
        op_kind_t          kind;
        logic [CH_W-1:0]   chan;
        logic [13:0]       start;
        logic [14:0]       length;   // already clamped
        logic [10:0]       incr;     // already looked up
        logic              loop_en;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
    } op_t;

    // Rate code to cursor increment; out-of-range codes saturate to fastest
    function automatic logic [10:0] rate_step(input logic [2:0] code);
        logic [10:0] step;
        case (rate_t'(code))
            RATE_1K:  step = STEP_1K;
            RATE_2K:  step = STEP_2K;
            RATE_4K:  step = STEP_4K;
            RATE_8K:  step = STEP_8K;
            RATE_16K: step = STEP_16K;
            default:  step = STEP_32K;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

### hdl/spmix_front.sv
// Front end: accepts input transfers, classifies them and queues operations.
`timescale 1ns / 1ps
`default_nettype none

module spmix_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  action,
    input  wire logic                        channel,
    input  wire logic [13:0]                 start_address,
    input  wire logic [14:0]                 length,
    input  wire logic [2:0]                  rate_code,
    input  wire logic                        loop_enable,
    input  wire logic [13:0]                 store_address,
    input  wire logic signed [7:0]           store_value,
    output logic                             q_valid,
    output spmix_pkg::op_t                   q_item,
    input  wire logic                        q_pop
);

    spmix_pkg::op_t                   q_mem [spmix_pkg::QUEUE_DEPTH];
    logic [spmix_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [spmix_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [spmix_pkg::QCNT_W-1:0]     count_reg, count_next;
    spmix_pkg::op_t                   op;
    logic                             keep;
    logic                             accept;
    logic                             push;
    logic [14:0]                      len_clamped;
    logic [spmix_pkg::WADDR_W-1:0]    waddr_wide;

    // Queue full stalls the input side
    assign in_stall = (count_reg == spmix_pkg::QCNT_W'(spmix_pkg::QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    assign len_clamped = (length > spmix_pkg::LENGTH_CAP) ? spmix_pkg::LENGTH_CAP : length;
    assign waddr_wide  = spmix_pkg::WADDR_W'(store_address);

    // Classify the incoming item; unused actions and absent channels are dropped
    always_comb
    begin
        op.kind    = spmix_pkg::OP_TICK;
        op.chan    = spmix_pkg::CH_W'(channel);
        op.start   = start_address;
        op.length  = len_clamped;
        op.incr    = spmix_pkg::rate_step(rate_code);
        op.loop_en = loop_enable;
        op.waddr   = waddr_wide[spmix_pkg::ADDR_W-1:0];
        op.wdata   = store_value;
        keep       = 1'b0;
        unique case (spmix_pkg::action_t'(action))
            spmix_pkg::ACT_TICK:
            begin
                op.kind = spmix_pkg::OP_TICK;
                keep    = 1'b1;
            end
            spmix_pkg::ACT_PLAY:
            begin
                op.kind = spmix_pkg::OP_PLAY;
                keep    = (32'(channel) < spmix_pkg::CHANNELS);
            end
            spmix_pkg::ACT_WRITE:
            begin
                op.kind = spmix_pkg::OP_WRITE;
                keep    = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

    // Pointer and count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= op;
        end
    end

endmodule

`default_nettype wire

### hdl/spmix_back.sv
// Back end: sample store, channel sequencer, scale/mix pipeline and result queue.
`timescale 1ns / 1ps
`default_nettype none

module spmix_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire spmix_pkg::op_t       q_item,
    output logic                      q_pop,
    input  wire logic [7:0]           vol [spmix_pkg::CHANNELS],
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                dac_value
);

    // Sample store
    logic [7:0]                       store_mem [spmix_pkg::STORE_DEPTH];
    logic [7:0]                       rd_data_reg;
    logic                             mem_we;
    logic                             mem_re;
    logic [spmix_pkg::ADDR_W-1:0]     mem_raddr;

    // Channel state
    logic [13:0]                      start_reg  [spmix_pkg::CHANNELS];
    logic [14:0]                      len_reg    [spmix_pkg::CHANNELS];
    logic [22:0]                      cursor_reg [spmix_pkg::CHANNELS];
    logic [10:0]                      incr_reg   [spmix_pkg::CHANNELS];
    logic [spmix_pkg::CHANNELS-1:0]   active_reg;
    logic [spmix_pkg::CHANNELS-1:0]   loop_reg;

    // Sequencer
    logic [spmix_pkg::CH_W-1:0]       ch_idx_reg, ch_idx_next;
    logic [spmix_pkg::OCNT_W-1:0]     resv_reg, resv_next;
    logic                             is_tick;
    logic                             first_ch;
    logic                             last_ch;
    logic                             tick_go;
    logic                             do_play;
    logic [22:0]                      cur;
    logic [22:0]                      cur_adv;
    logic                             at_end;
    logic [spmix_pkg::SUM_W-1:0]      addr_sum;

    // Pipeline stages
    logic                             s1_vld_reg, s1_use_reg, s1_first_reg, s1_last_reg;
    logic [7:0]                       s1_vol_reg;
    logic                             s2_vld_reg, s2_use_reg, s2_first_reg, s2_last_reg;
    logic signed [16:0]               prod_reg;
    logic signed [16:0]               prod_next;
    logic signed [spmix_pkg::ACC_W-1:0] acc_reg;
    logic signed [spmix_pkg::ACC_W-1:0] term;
    logic signed [spmix_pkg::ACC_W-1:0] sum;
    logic signed [spmix_pkg::ACC_W:0]   mixed;
    logic [7:0]                       dac_clamped;
    logic                             push_res;

    // Result queue
    logic [7:0]                       oq_mem [spmix_pkg::OUT_DEPTH];
    logic [spmix_pkg::OPTR_W-1:0]     owr_ptr_reg, ord_ptr_reg;
    logic [spmix_pkg::OCNT_W-1:0]     ocount_reg, ocount_next;
    logic                             out_xfer;

    // Decode the queue head
    assign is_tick  = q_valid && (q_item.kind == spmix_pkg::OP_TICK);
    assign first_ch = (ch_idx_reg == '0);
    assign last_ch  = (ch_idx_reg == spmix_pkg::CH_W'(spmix_pkg::CHANNELS - 1));
    // A tick starts only with a free result slot reserved
    assign tick_go  = is_tick &&
                      (!first_ch || (resv_reg < spmix_pkg::OCNT_W'(spmix_pkg::OUT_DEPTH)));
    assign do_play  = q_valid && (q_item.kind == spmix_pkg::OP_PLAY);
    assign mem_we   = q_valid && (q_item.kind == spmix_pkg::OP_WRITE);
    assign q_pop    = q_valid && (!is_tick || (tick_go && last_ch));
    assign mem_re   = tick_go;

    // Cursor advance and read address for the current channel
    assign cur       = cursor_reg[ch_idx_reg];
    assign cur_adv   = cur + {12'd0, incr_reg[ch_idx_reg]};
    assign at_end    = (cur_adv[22:8] >= len_reg[ch_idx_reg]);
    assign addr_sum  = spmix_pkg::SUM_W'(start_reg[ch_idx_reg]) + spmix_pkg::SUM_W'(cur[22:8]);
    assign mem_raddr = addr_sum[spmix_pkg::ADDR_W-1:0];

    always_comb
    begin
        ch_idx_next = ch_idx_reg;
        if (tick_go)
        begin
            ch_idx_next = last_ch ? '0 : ch_idx_reg + 1'b1;
        end
    end

    // Reservation count: slots held by ticks in flight or results waiting
    always_comb
    begin
        resv_next = resv_reg;
        if (tick_go && first_ch && !out_xfer)
        begin
            resv_next = resv_reg + 1'b1;
        end
        else if (!(tick_go && first_ch) && out_xfer)
        begin
            resv_next = resv_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_idx_reg <= '0;
            resv_reg   <= '0;
        end
        else
        begin
            ch_idx_reg <= ch_idx_next;
            resv_reg   <= resv_next;
        end
    end

    // Channel state: play items load it, ticks advance it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < spmix_pkg::CHANNELS; c++)
            begin
                start_reg[c]  <= '0;
                len_reg[c]    <= '0;
                cursor_reg[c] <= '0;
                incr_reg[c]   <= '0;
            end
            active_reg <= '0;
            loop_reg   <= '0;
        end
        else if (do_play)
        begin
            start_reg[q_item.chan]  <= q_item.start;
            len_reg[q_item.chan]    <= q_item.length;
            cursor_reg[q_item.chan] <= '0;
            incr_reg[q_item.chan]   <= q_item.incr;
            loop_reg[q_item.chan]   <= q_item.loop_en;
            active_reg[q_item.chan] <= 1'b1;
        end
        else if (tick_go && active_reg[ch_idx_reg])
        begin
            if (at_end)
            begin
                cursor_reg[ch_idx_reg] <= '0;
                if (!loop_reg[ch_idx_reg])
                begin
                    active_reg[ch_idx_reg] <= 1'b0;
                end
            end
            else
            begin
                cursor_reg[ch_idx_reg] <= cur_adv;
            end
        end
    end

    // Sample store, single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[q_item.waddr] <= q_item.wdata;
        end
        else if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    // Stage 1 control: travels alongside the store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_use_reg   <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_vol_reg   <= '0;
        end
        else
        begin
            s1_vld_reg   <= tick_go;
            s1_use_reg   <= active_reg[ch_idx_reg];
            s1_first_reg <= first_ch;
            s1_last_reg  <= last_ch;
            s1_vol_reg   <= vol[ch_idx_reg];
        end
    end

    // Stage 2: scale by volume
    assign prod_next = $signed(rd_data_reg) * $signed({1'b0, s1_vol_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg   <= 1'b0;
            s2_use_reg   <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            prod_reg     <= '0;
        end
        else
        begin
            s2_vld_reg   <= s1_vld_reg;
            s2_use_reg   <= s1_use_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            prod_reg     <= prod_next;
        end
    end

    // Stage 3: floor shift, accumulate, offset and clamp on the last channel
    assign term = s2_use_reg ? spmix_pkg::ACC_W'($signed(prod_reg[16:8])) : '0;
    assign sum  = (s2_first_reg ? '0 : acc_reg) + term;
    assign mixed = {sum[spmix_pkg::ACC_W-1], sum} + spmix_pkg::DAC_OFFSET;

    always_comb
    begin
        if (mixed < 0)
        begin
            dac_clamped = 8'd0;
        end
        else if (mixed > spmix_pkg::DAC_MAX)
        begin
            dac_clamped = 8'd255;
        end
        else
        begin
            dac_clamped = mixed[7:0];
        end
    end

    assign push_res = s2_vld_reg && s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= sum;
        end
    end

    // Result queue; the reservation count keeps it from overflowing
    assign out_valid = (ocount_reg != '0);
    assign out_xfer  = out_valid && !out_stall;
    assign dac_value = oq_mem[ord_ptr_reg];

    always_comb
    begin
        ocount_next = ocount_reg;
        if (push_res && !out_xfer)
        begin
            ocount_next = ocount_reg + 1'b1;
        end
        else if (!push_res && out_xfer)
        begin
            ocount_next = ocount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            ocount_reg <= ocount_next;
            if (push_res)
            begin
                owr_ptr_reg <= owr_ptr_reg + 1'b1;
            end
            if (out_xfer)
            begin
                ord_ptr_reg <= ord_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_res)
        begin
            oq_mem[owr_ptr_reg] <= dac_clamped;
        end
    end

endmodule

`default_nettype wire

### hdl/sample_playback_mixer.sv
// Top level of the two-channel sample playback mixer: volume registers and wiring.
//
//  Port group   Dir  Handshake               Carries
//  in_*         in   in_valid / in_stall     action, channel, start_address, length,
//                                            rate_code, loop_enable, store_address,
//                                            store_value
//  out_*        out  out_valid / out_stall   dac_value (one per tick)
//  cfg_*        in   cfg_write_en            cfg_index, cfg_data (volume_ch0, volume_ch1)
//
//  A tick steps the sequencer through every channel, one sample store read per
//  channel through the single store port; play and write items pop straight away.
//  A result passes the read data, product and result queue registers in turn.
//  A four-entry queue sits between front and back; a four-entry result queue drives out.
//  Reset clears control and channel state; the sample store is not cleared.
//  out_stall holds results queued; ticks wait only when every result slot is reserved.
`timescale 1ns / 1ps
`default_nettype none

module sample_playback_mixer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        action,
    input  wire logic              channel,
    input  wire logic [13:0]       start_address,
    input  wire logic [14:0]       length,
    input  wire logic [2:0]        rate_code,
    input  wire logic              loop_enable,
    input  wire logic [13:0]       store_address,
    input  wire logic signed [7:0] store_value,
    // Output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             dac_value,
    // Configuration
    input  wire logic              cfg_write_en,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [7:0]        cfg_data
);

    logic [7:0]     vol_ch0_reg;
    logic [7:0]     vol_ch1_reg;
    logic [7:0]     vol [spmix_pkg::CHANNELS];
    logic           q_valid;
    logic           q_pop;
    spmix_pkg::op_t q_item;

    // Volume registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_ch0_reg <= spmix_pkg::VOL_RESET;
            vol_ch1_reg <= spmix_pkg::VOL_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (spmix_pkg::cfg_reg_t'(cfg_index))
                spmix_pkg::CFG_VOLUME_CH0: vol_ch0_reg <= cfg_data;
                spmix_pkg::CFG_VOLUME_CH1: vol_ch1_reg <= cfg_data;
                default:                   vol_ch0_reg <= vol_ch0_reg;
            endcase
        end
    end

    // Per-channel volume; channels without a register play at full scale
    always_comb
    begin
        for (int c = 0; c < spmix_pkg::CHANNELS; c++)
        begin
            if (c == 0)
            begin
                vol[c] = vol_ch0_reg;
            end
            else if (c == 1)
            begin
                vol[c] = vol_ch1_reg;
            end
            else
            begin
                vol[c] = spmix_pkg::VOL_RESET;
            end
        end
    end

    spmix_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .channel       (channel),
        .start_address (start_address),
        .length        (length),
        .rate_code     (rate_code),
        .loop_enable   (loop_enable),
        .store_address (store_address),
        .store_value   (store_value),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    spmix_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .vol       (vol),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dac_value (dac_value)
    );

endmodule

`default_nettype wire
